/* sv/iiee_pkg.sv */
// Shared types and constants for the infix integer expression evaluator.
// Used by the controller, the datapath and the top level; depends on nothing.
package iiee_pkg;

	localparam int OUT_DATA_W = 40;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_OVF  = 2'd2;
	localparam logic [1:0] ERR_CHAR = 2'd3;

	typedef enum logic [1:0] {
		MULOP_NONE,
		MULOP_MUL,
		MULOP_DIV
	} mulop_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_MUL,
		ST_DIV,
		ST_AFTER,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_DIGIT,
		CMD_STRAY,
		CMD_TERM_LOAD,
		CMD_MUL_START,
		CMD_MUL_STEP,
		CMD_DIV_START,
		CMD_DIV_STEP,
		CMD_DIV_ZERO,
		CMD_SET_MULOP,
		CMD_ADD_TERM,
		CMD_EMIT
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t    cmd;
		logic [3:0] digit;
		logic       is_div;
		logic       is_minus;
	} dp_ctrl_t;

	typedef struct packed {
		logic   err;
		logic   num_zero;
		logic   iter_last;
		mulop_t mulop;
	} dp_status_t;

endpackage

/* sv/iiee_dp.sv */
// Datapath of the expression evaluator: accumulators, error latch, a shared
// bit-serial multiply/divide unit and the result register. Uses iiee_pkg.
module iiee_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iiee_pkg::dp_ctrl_t    ctrl,
	output iiee_pkg::dp_status_t  status,
	output logic [31:0]           value,
	output logic [1:0]            error_code
);
	import iiee_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int CW = $clog2(W);
	localparam logic [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};
	localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

	logic signed [W-1:0] sum_q;
	logic signed [W-1:0] term_q;
	logic [W-1:0]        num_q;
	logic                minus_q;
	mulop_t              mulop_q;
	logic [1:0]          err_q;

	// Shared iteration registers: multiplicand or dividend/quotient, multiplier
	// or divisor, partial product or remainder.
	logic [W-1:0]  mag_q;
	logic [W-1:0]  dsr_q;
	logic [W-1:0]  acc_q;
	logic          neg_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_q;

	logic [31:0] value_q;
	logic [1:0]  error_code_q;

	logic [W+3:0]        num_wide;
	logic                digit_ovf;
	logic [W-1:0]        term_mag;
	logic [W:0]          mul_wide;
	logic [W:0]          mul_limit;
	logic                mul_over;
	logic [W-1:0]        mul_res;
	logic [W-1:0]        div_r;
	logic                div_ge;
	logic [W-1:0]        div_rem;
	logic [W-1:0]        div_quot;
	logic [W-1:0]        div_res;
	logic signed [W:0]   add_b;
	logic signed [W+1:0] add_sum;
	logic                add_ovf;
	logic signed [W-1:0] res;
	logic                ok;

	assign ok = (err_q == ERR_OK);

	assign num_wide  = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + (W+4)'(ctrl.digit);
	assign digit_ovf = |num_wide[W+3:W-1];

	assign term_mag = term_q[W-1] ? (W)'(-term_q) : term_q;

	assign mul_wide  = {acc_q, 1'b0} + (dsr_q[W-1] ? {1'b0, mag_q} : '0);
	assign mul_limit = {1'b0, (neg_q ? VMIN : VMAX)};
	assign mul_over  = mul_wide > mul_limit;
	assign mul_res   = neg_q ? (W)'(-mul_wide[W-1:0]) : mul_wide[W-1:0];

	// The remainder stays below the divisor, which is at most the largest value.
	assign div_r    = {acc_q[W-2:0], mag_q[W-1]};
	assign div_ge   = div_r >= dsr_q;
	assign div_rem  = div_ge ? div_r - dsr_q : div_r;
	assign div_quot = {mag_q[W-2:0], div_ge};
	assign div_res  = neg_q ? (W)'(-div_quot) : div_quot;

	assign add_b   = minus_q ? -(W+1)'(term_q) : (W+1)'(term_q);
	assign add_sum = (W+2)'(sum_q) + (W+2)'(add_b);
	assign add_ovf = !(add_sum[W+1] == add_sum[W] && add_sum[W] == add_sum[W-1])
		|| (minus_q && term_q == VMIN);

	assign res = ok ? sum_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			term_q  <= '0;
			num_q   <= '0;
			minus_q <= 1'b0;
			mulop_q <= MULOP_NONE;
			err_q   <= ERR_OK;
		end else begin
			unique case (ctrl.cmd)
				CMD_DIGIT: begin
					if (ok) begin
						if (digit_ovf) err_q <= ERR_OVF;
						else num_q <= num_wide[W-1:0];
					end
				end
				CMD_STRAY: begin
					if (ok) err_q <= ERR_CHAR;
				end
				CMD_TERM_LOAD: begin
					if (ok) begin
						term_q <= num_q;
						num_q  <= '0;
					end
				end
				CMD_MUL_STEP: begin
					if (cnt_q == '0 && ok) begin
						if (ovf_q || mul_over) err_q <= ERR_OVF;
						else begin
							term_q <= mul_res;
							num_q  <= '0;
						end
					end
				end
				CMD_DIV_STEP: begin
					if (cnt_q == '0 && ok) begin
						term_q <= div_res;
						num_q  <= '0;
					end
				end
				CMD_DIV_ZERO: begin
					if (ok) err_q <= ERR_DIV0;
				end
				CMD_SET_MULOP: begin
					mulop_q <= ctrl.is_div ? MULOP_DIV : MULOP_MUL;
				end
				CMD_ADD_TERM: begin
					if (ok) begin
						if (add_ovf) err_q <= ERR_OVF;
						else begin
							sum_q   <= add_sum[W-1:0];
							term_q  <= '0;
							mulop_q <= MULOP_NONE;
						end
					end
					minus_q <= ctrl.is_minus;
				end
				CMD_EMIT: begin
					sum_q   <= '0;
					term_q  <= '0;
					num_q   <= '0;
					minus_q <= 1'b0;
					mulop_q <= MULOP_NONE;
					err_q   <= ERR_OK;
				end
				default: begin
				end
			endcase
		end
	end

	// Iteration registers and the result register carry no reset.
	always_ff @(posedge clk) begin
		unique case (ctrl.cmd)
			CMD_MUL_START, CMD_DIV_START: begin
				mag_q <= term_mag;
				dsr_q <= num_q;
				acc_q <= '0;
				neg_q <= term_q[W-1];
				ovf_q <= 1'b0;
				cnt_q <= CNT_TOP;
			end
			CMD_MUL_STEP: begin
				// Once the product passes the limit it is kept where it was.
				if (mul_over) ovf_q <= 1'b1;
				else if (!ovf_q) acc_q <= mul_wide[W-1:0];
				dsr_q <= {dsr_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			CMD_DIV_STEP: begin
				acc_q <= div_rem;
				mag_q <= div_quot;
				cnt_q <= cnt_q - 1'b1;
			end
			CMD_EMIT: begin
				value_q      <= 32'(res);
				error_code_q <= err_q;
			end
			default: begin
			end
		endcase
	end

	assign status.err       = !ok;
	assign status.num_zero  = (num_q == '0);
	assign status.iter_last = (cnt_q == '0);
	assign status.mulop     = mulop_q;

	assign value      = value_q;
	assign error_code = error_code_q;

endmodule

/* sv/iiee_ctrl.sv */
// Controller of the expression evaluator: character decode, sequencing of the
// datapath and the input and output handshakes. Uses iiee_pkg.
module iiee_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            char_code,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output iiee_pkg::dp_ctrl_t    ctrl,
	input  iiee_pkg::dp_status_t  status
);
	import iiee_pkg::*;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [2:0] {
		KIND_DIGIT,
		KIND_MUL,
		KIND_DIV,
		KIND_ADD,
		KIND_SUB,
		KIND_SPACE,
		KIND_STRAY,
		KIND_END
	} kind_t;

	state_t state_q, state_d;
	kind_t  kind_q;
	kind_t  kind_in;
	logic   last_q;
	logic   out_valid_q;
	logic   accept;
	logic   is_op;
	logic   emit;

	always_comb begin
		priority if (char_code >= CH_0 && char_code <= CH_9) kind_in = KIND_DIGIT;
		else if (char_code == CH_MUL)                        kind_in = KIND_MUL;
		else if (char_code == CH_DIV)                        kind_in = KIND_DIV;
		else if (char_code == CH_ADD)                        kind_in = KIND_ADD;
		else if (char_code == CH_SUB)                        kind_in = KIND_SUB;
		else if (char_code == CH_SPACE || char_code == CH_TAB) kind_in = KIND_SPACE;
		else                                                 kind_in = KIND_STRAY;
	end

	assign is_op  = (kind_in == KIND_MUL) || (kind_in == KIND_DIV)
		|| (kind_in == KIND_ADD) || (kind_in == KIND_SUB);
	assign accept = s_tvalid && s_tready;
	assign emit   = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (is_op || s_tlast)) state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				priority if (status.err) state_d = ST_AFTER;
				else if (status.mulop == MULOP_MUL) state_d = ST_MUL;
				else if (status.mulop == MULOP_DIV && !status.num_zero) state_d = ST_DIV;
				else state_d = ST_AFTER;
			end
			ST_MUL, ST_DIV: begin
				if (status.iter_last) state_d = ST_AFTER;
			end
			ST_AFTER: begin
				priority if (last_q && kind_q != KIND_END) state_d = ST_CLOSE;
				else if (last_q) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.cmd      = CMD_NOP;
		ctrl.digit    = 4'(char_code - CH_0);
		ctrl.is_div   = (kind_q == KIND_DIV);
		ctrl.is_minus = (kind_q == KIND_SUB);
		s_tready      = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind_in == KIND_DIGIT) ctrl.cmd = CMD_DIGIT;
				else if (accept && kind_in == KIND_STRAY) ctrl.cmd = CMD_STRAY;
			end
			ST_CLOSE: begin
				priority if (status.err) ctrl.cmd = CMD_NOP;
				else if (status.mulop == MULOP_MUL) ctrl.cmd = CMD_MUL_START;
				else if (status.mulop == MULOP_DIV && status.num_zero) ctrl.cmd = CMD_DIV_ZERO;
				else if (status.mulop == MULOP_DIV) ctrl.cmd = CMD_DIV_START;
				else ctrl.cmd = CMD_TERM_LOAD;
			end
			ST_MUL: ctrl.cmd = CMD_MUL_STEP;
			ST_DIV: ctrl.cmd = CMD_DIV_STEP;
			ST_AFTER: begin
				if (kind_q == KIND_MUL || kind_q == KIND_DIV) ctrl.cmd = CMD_SET_MULOP;
				else ctrl.cmd = CMD_ADD_TERM;
			end
			ST_EMIT: begin
				if (emit) ctrl.cmd = CMD_EMIT;
			end
			default: ctrl.cmd = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_END;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				kind_q <= is_op ? kind_in : KIND_END;
				last_q <= s_tlast;
			end else if (state_q == ST_AFTER && last_q) begin
				// A final operator still owes the closing of the expression.
				kind_q <= KIND_END;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

/* sv/infix_integer_expression_eval.sv */
// Top level of the infix integer expression evaluator: joins the controller
// and the datapath to the stream ports. Depends on iiee_pkg, iiee_ctrl, iiee_dp.
//
//   port group  dir  payload
//   s_*         in   s_tdata: char_code[7:0]; s_tlast: last_char
//   m_*         out  m_tdata: value[31:0], error_code[33:32], zero[39:34]
//
// A digit, space, tab or stray character is taken while the block stays idle. An
// operator, or the last character, closes the pending number, running the
// one-bit-per-cycle shift-add and restoring-divide unit when a multiply or divide
// is pending. A last character that is itself an operator runs the close twice,
// and the result then passes through the emit state into the output register.
// Reset clears all accumulators. A held result stalls only the next result.
module infix_integer_expression_eval #(
	parameter int VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // char_code
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [iiee_pkg::OUT_DATA_W-1:0]     m_tdata   // value, error_code, zeros
);
	import iiee_pkg::*;

	dp_ctrl_t    ctrl;
	dp_status_t  status;
	logic [31:0] value;
	logic [1:0]  error_code;

	iiee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.char_code (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.ctrl      (ctrl),
		.status    (status)
	);

	iiee_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.status     (status),
		.value      (value),
		.error_code (error_code)
	);

	assign m_tdata = {(OUT_DATA_W - 34)'(0), error_code, value};

endmodule

/* sv/iiee_chk.sv */
// Port-level checker for the expression evaluator, bound to the top level.
// Depends only on the top level's ports.
module iiee_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A result that is not taken stays as it was.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An error result carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0)
		else $error("nonzero value with error code");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0)
		else $error("padding bits not zero");

	// Closing the expression always takes the block away from the input.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after last character");

endmodule

bind infix_integer_expression_eval iiee_chk u_iiee_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
